FILE: src/trrq_pkg.sv
package trrq_pkg;

	// Coordinate and edge vector widths.
	localparam int CW    = 32;
	localparam int DW    = 33;
	// Products of edge vector component pairs, and their sums.
	localparam int PW    = 66;
	localparam int ESQW  = 66;
	localparam int CXW   = 67;
	// Squared length of a face cross product, one component and all three.
	localparam int FCW   = 131;
	localparam int FSQW  = 132;
	// Triple product terms, the determinant and its magnitude.
	localparam int TTW   = 100;
	localparam int DETW  = 102;
	localparam int DABSW = 101;
	// Square root units: face root with 48 and edge root with 32 fraction bits.
	localparam int FRW   = 82;
	localparam int FRADW = 2 * FRW;
	localparam int FREMW = FRW + 2;
	localparam int ERW   = 49;
	localparam int ERADW = 2 * ERW;
	localparam int EREMW = ERW + 2;
	localparam int SUMW  = 84;
	// Scale constant and the numerator product.
	localparam int KW    = 46;
	localparam int KPW   = 64;
	localparam int P1W   = 95;
	localparam int ROWW  = 116;
	localparam int PRODW = 179;
	localparam int NUMW  = 117;
	localparam int D2W   = DABSW + 1;
	localparam int QW    = 33;
	localparam int CMPW  = D2W + QW;

	localparam int SQ_STAGES  = FRW;
	localparam int DIV_STAGES = QW;

	localparam logic [CW-1:0] QUAL_POS_SAT = 32'h7FFF_FFFF;
	localparam logic [CW-1:0] QUAL_NEG_SAT = 32'h8000_0000;

	// floor(sqrt(2^96 / 24)): sqrt(6)/12 with 48 fraction bits.
	function automatic logic [KW-1:0] k_calc();
		logic [95:0]   rad;
		logic [95:0]   sq;
		logic [KW-1:0] res;
		logic [KW-1:0] cand;
		rad = (96'd1 << 93) / 96'd3;
		res = '0;
		for (int b = KW - 1; b >= 0; b--) begin
			cand = res | (KW'(1) << b);
			sq   = 96'(cand) * 96'(cand);
			if (sq <= rad) res = cand;
		end
		return res;
	endfunction

	localparam logic [KW-1:0] K_SQRT6_12 = k_calc();

endpackage

FILE: src/tetra_radius_ratio_quality_top.sv
// Radius ratio quality of one tetrahedron.
// Input channel: in_valid/in_ready with the four node coordinates, each axis
// a signed Q16.16 word. Output channel: out_valid/out_ready with quality
// (signed Q16.16, saturated) and degenerate (zero volume or zero face area,
// quality then reads as the positive limit).
// The datapath is one pipeline: six stages of edge vectors, products, cross
// products and the triple product, 82 stages of a bit-per-stage square root
// (face roots and the longest-edge root side by side), eight stages that
// build the numerator, and 33 stages of a bit-per-stage divider that yields
// the rounded quotient. A new transaction is accepted in every cycle while
// the receiver does not stall.
// When the receiver stalls (out_valid high, out_ready low) the whole pipeline
// holds, and in_ready is low until the waiting result is taken; nothing is
// dropped or repeated. Reset clears only the valid bits, so the block comes
// out of reset empty and ready.
module tetra_radius_ratio_quality_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [trrq_pkg::CW-1:0]    node0_x,
	input  logic signed [trrq_pkg::CW-1:0]    node0_y,
	input  logic signed [trrq_pkg::CW-1:0]    node0_z,
	input  logic signed [trrq_pkg::CW-1:0]    node1_x,
	input  logic signed [trrq_pkg::CW-1:0]    node1_y,
	input  logic signed [trrq_pkg::CW-1:0]    node1_z,
	input  logic signed [trrq_pkg::CW-1:0]    node2_x,
	input  logic signed [trrq_pkg::CW-1:0]    node2_y,
	input  logic signed [trrq_pkg::CW-1:0]    node2_z,
	input  logic signed [trrq_pkg::CW-1:0]    node3_x,
	input  logic signed [trrq_pkg::CW-1:0]    node3_y,
	input  logic signed [trrq_pkg::CW-1:0]    node3_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [trrq_pkg::CW-1:0]    quality,
	output logic                              degenerate
);
	import trrq_pkg::*;

	localparam int LAT = 6 + SQ_STAGES + 8 + DIV_STAGES + 1;

	// Edges 01 02 03 12 13 23 as node pairs.
	localparam int EA [6] = '{0, 0, 0, 1, 1, 2};
	localparam int EB [6] = '{1, 2, 3, 2, 3, 3};
	// Face cross product operands as edge indices.
	localparam int FU [4] = '{1, 0, 3, 2};
	localparam int FV [4] = '{0, 2, 4, 1};
	localparam int NX [3] = '{1, 2, 0};
	localparam int NY [3] = '{2, 0, 1};

	logic              adv;
	logic [LAT-1:0]    vld_q;
	logic signed [CW-1:0] p [4][3];

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];

	assign p[0][0] = node0_x;
	assign p[0][1] = node0_y;
	assign p[0][2] = node0_z;
	assign p[1][0] = node1_x;
	assign p[1][1] = node1_y;
	assign p[1][2] = node1_z;
	assign p[2][0] = node2_x;
	assign p[2][1] = node2_y;
	assign p[2][2] = node2_z;
	assign p[3][0] = node3_x;
	assign p[3][1] = node3_y;
	assign p[3][2] = node3_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// ---------------- geometry stages ----------------
	logic signed [DW-1:0]   e_s1    [6][3];
	logic signed [PW-1:0]   esq_s2  [6][3];
	logic signed [PW-1:0]   xa_s2   [4][3];
	logic signed [PW-1:0]   xb_s2   [4][3];
	logic signed [DW-1:0]   e0_s2   [3];
	logic        [ESQW-1:0] esum_s3 [6];
	logic signed [CXW-1:0]  c_s3    [4][3];
	logic signed [DW-1:0]   e0_s3   [3];
	logic        [PW-1:0]   cabs    [4][3];
	logic        [CXW-1:0]  cneg    [4][3];
	logic        [PW-1:0]   pp_s4   [4][3][3];
	logic signed [CXW-1:0]  tch_s4  [3];
	logic signed [CXW-1:0]  tcl_s4  [3];
	logic        [ESQW-1:0] emax_s4 [3];
	logic        [FCW-1:0]  fc_s5   [4][3];
	logic signed [TTW-1:0]  tt_s5   [3];
	logic        [ESQW-1:0] emax_s5 [2];
	logic        [FSQW-1:0] fsq_s6  [4];
	logic signed [DETW-1:0] d_s6;
	logic        [ESQW-1:0] emax_s6;

	always_comb begin
		for (int f = 0; f < 4; f++) begin
			for (int k = 0; k < 3; k++) begin
				cneg[f][k] = -c_s3[f][k];
				cabs[f][k] = c_s3[f][k][CXW-1] ? cneg[f][k][PW-1:0] : c_s3[f][k][PW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 6; e++) begin
				for (int k = 0; k < 3; k++) begin
					e_s1[e][k]   <= DW'(p[EB[e]][k]) - DW'(p[EA[e]][k]);
					esq_s2[e][k] <= e_s1[e][k] * e_s1[e][k];
				end
				esum_s3[e] <= $unsigned(esq_s2[e][0]) + $unsigned(esq_s2[e][1])
					+ $unsigned(esq_s2[e][2]);
			end
			for (int f = 0; f < 4; f++) begin
				for (int k = 0; k < 3; k++) begin
					xa_s2[f][k] <= e_s1[FU[f]][NX[k]] * e_s1[FV[f]][NY[k]];
					xb_s2[f][k] <= e_s1[FU[f]][NY[k]] * e_s1[FV[f]][NX[k]];
					c_s3[f][k]  <= CXW'(xa_s2[f][k]) - CXW'(xb_s2[f][k]);
					// Square split into 33-bit halves; the cross term counts twice.
					pp_s4[f][k][0] <= cabs[f][k][PW-1:DW] * cabs[f][k][PW-1:DW];
					pp_s4[f][k][1] <= cabs[f][k][PW-1:DW] * cabs[f][k][DW-1:0];
					pp_s4[f][k][2] <= cabs[f][k][DW-1:0] * cabs[f][k][DW-1:0];
					fc_s5[f][k] <= (FCW'(pp_s4[f][k][0]) << 66) + (FCW'(pp_s4[f][k][1]) << 34)
						+ FCW'(pp_s4[f][k][2]);
				end
				fsq_s6[f] <= FSQW'(fc_s5[f][0]) + FSQW'(fc_s5[f][1]) + FSQW'(fc_s5[f][2]);
			end
			for (int k = 0; k < 3; k++) begin
				e0_s2[k]  <= e_s1[0][k];
				e0_s3[k]  <= e0_s2[k];
				// Edge 01 dotted with the face 3 cross product, split at bit 33.
				tch_s4[k] <= e0_s3[k] * $signed(c_s3[3][k][CXW-1:DW]);
				tcl_s4[k] <= e0_s3[k] * $signed({1'b0, c_s3[3][k][DW-1:0]});
				tt_s5[k]  <= (TTW'(tch_s4[k]) <<< 33) + TTW'(tcl_s4[k]);
			end
			for (int i = 0; i < 3; i++) begin
				emax_s4[i] <= (esum_s3[2*i] >= esum_s3[2*i+1]) ? esum_s3[2*i] : esum_s3[2*i+1];
			end
			emax_s5[0] <= (emax_s4[0] >= emax_s4[1]) ? emax_s4[0] : emax_s4[1];
			emax_s5[1] <= emax_s4[2];
			emax_s6    <= (emax_s5[0] >= emax_s5[1]) ? emax_s5[0] : emax_s5[1];
			// Face 3 runs opposite to the volume's orientation, hence the negation.
			d_s6 <= -(DETW'(tt_s5[0]) + DETW'(tt_s5[1]) + DETW'(tt_s5[2]));
		end
	end

	// ---------------- square root stages ----------------
	logic [FRADW-1:0]     fr_rad_s  [SQ_STAGES][4];
	logic [FREMW-1:0]     fr_rem_s  [SQ_STAGES][4];
	logic [FRW-1:0]       fr_root_s [SQ_STAGES][4];
	logic [ERADW-1:0]     er_rad_s  [SQ_STAGES];
	logic [EREMW-1:0]     er_rem_s  [SQ_STAGES];
	logic [ERW-1:0]       er_root_s [SQ_STAGES];
	logic [DABSW-1:0]     sq_dabs_s [SQ_STAGES];
	logic [SQ_STAGES-1:0] sq_neg_s;
	logic [SQ_STAGES-1:0] sq_degen_s;

	logic [DETW-1:0]  dneg0;
	logic [DABSW-1:0] dabs0;
	logic             degen0;

	always_comb begin
		dneg0  = -d_s6;
		dabs0  = d_s6[DETW-1] ? dneg0[DABSW-1:0] : d_s6[DABSW-1:0];
		degen0 = (d_s6 == '0) || ((fsq_s6[0] == '0) && (fsq_s6[1] == '0)
			&& (fsq_s6[2] == '0) && (fsq_s6[3] == '0));
	end

	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
		logic [FRADW-1:0] f_rad  [4];
		logic [FREMW-1:0] f_rem  [4];
		logic [FRW-1:0]   f_root [4];
		logic [FREMW-1:0] f_r2   [4];
		logic [FREMW-1:0] f_try  [4];
		logic [ERADW-1:0] e_rad;
		logic [EREMW-1:0] e_rem;
		logic [ERW-1:0]   e_root;
		logic [EREMW-1:0] e_r2;
		logic [EREMW-1:0] e_try;
		logic [DABSW-1:0] s_dabs;
		logic             s_neg;
		logic             s_degen;

		if (j == 0) begin : g_src
			always_comb begin
				for (int f = 0; f < 4; f++) begin
					f_rad[f]  = {fsq_s6[f], 32'b0};
					f_rem[f]  = '0;
					f_root[f] = '0;
				end
				e_rad   = {emax_s6, 32'b0};
				e_rem   = '0;
				e_root  = '0;
				s_dabs  = dabs0;
				s_neg   = d_s6[DETW-1];
				s_degen = degen0;
			end
		end else begin : g_src
			always_comb begin
				for (int f = 0; f < 4; f++) begin
					f_rad[f]  = fr_rad_s[j-1][f];
					f_rem[f]  = fr_rem_s[j-1][f];
					f_root[f] = fr_root_s[j-1][f];
				end
				e_rad   = er_rad_s[j-1];
				e_rem   = er_rem_s[j-1];
				e_root  = er_root_s[j-1];
				s_dabs  = sq_dabs_s[j-1];
				s_neg   = sq_neg_s[j-1];
				s_degen = sq_degen_s[j-1];
			end
		end

		always_comb begin
			for (int f = 0; f < 4; f++) begin
				f_r2[f]  = {f_rem[f][FREMW-3:0], f_rad[f][FRADW-1 -: 2]};
				f_try[f] = {f_root[f], 2'b01};
			end
			e_r2  = {e_rem[EREMW-3:0], e_rad[ERADW-1 -: 2]};
			e_try = {e_root, 2'b01};
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int f = 0; f < 4; f++) begin
					fr_rad_s[j][f] <= f_rad[f] << 2;
					if (f_r2[f] >= f_try[f]) begin
						fr_rem_s[j][f]  <= f_r2[f] - f_try[f];
						fr_root_s[j][f] <= {f_root[f][FRW-2:0], 1'b1};
					end else begin
						fr_rem_s[j][f]  <= f_r2[f];
						fr_root_s[j][f] <= {f_root[f][FRW-2:0], 1'b0};
					end
				end
				er_rad_s[j] <= e_rad << 2;
				// The edge root is shorter and only rides along after its last bit.
				if (j >= ERW) begin
					er_rem_s[j]  <= e_rem;
					er_root_s[j] <= e_root;
				end else if (e_r2 >= e_try) begin
					er_rem_s[j]  <= e_r2 - e_try;
					er_root_s[j] <= {e_root[ERW-2:0], 1'b1};
				end else begin
					er_rem_s[j]  <= e_r2;
					er_root_s[j] <= {e_root[ERW-2:0], 1'b0};
				end
				sq_dabs_s[j]  <= s_dabs;
				sq_neg_s[j]   <= s_neg;
				sq_degen_s[j] <= s_degen;
			end
		end
	end

	// ---------------- numerator stages ----------------
	localparam int SL = SQ_STAGES - 1;

	logic [SUMW-1:0]  sum_a1;
	logic [ERW-1:0]   hs_a1;
	logic [SUMW-1:0]  sum_a2;
	logic [SUMW-1:0]  sum_a3;
	logic [KPW-1:0]   kp_a2 [4];
	logic [P1W-1:0]   p1_a3;
	logic [KPW-1:0]   pp_a4 [3][3];
	logic [ROWW-1:0]  row_a5 [3];
	logic [PRODW-1:0] prod_a6;
	logic [NUMW-1:0]  num_a7;
	logic [D2W-1:0]   d2_a7;
	logic [DABSW-1:0] dabs_a [6];
	logic [7:0]       neg_a;
	logic [7:0]       degen_a;
	logic [31:0]      p1c [3];
	logic [31:0]      sc  [3];
	logic             ovf_a8;
	logic [NUMW-1:0]  rem_a8;
	logic [D2W-1:0]   d2_a8;

	always_comb begin
		p1c[0] = p1_a3[31:0];
		p1c[1] = p1_a3[63:32];
		p1c[2] = 32'(p1_a3[P1W-1:64]);
		sc[0]  = sum_a3[31:0];
		sc[1]  = sum_a3[63:32];
		sc[2]  = 32'(sum_a3[SUMW-1:64]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_a1 <= SUMW'(fr_root_s[SL][0]) + SUMW'(fr_root_s[SL][1])
				+ SUMW'(fr_root_s[SL][2]) + SUMW'(fr_root_s[SL][3]);
			hs_a1  <= er_root_s[SL];
			kp_a2[0] <= K_SQRT6_12[KW-1:32] * hs_a1[ERW-1:32];
			kp_a2[1] <= K_SQRT6_12[KW-1:32] * hs_a1[31:0];
			kp_a2[2] <= K_SQRT6_12[31:0] * hs_a1[ERW-1:32];
			kp_a2[3] <= K_SQRT6_12[31:0] * hs_a1[31:0];
			sum_a2 <= sum_a1;
			p1_a3  <= (P1W'(kp_a2[0]) << 64) + (P1W'(kp_a2[1]) << 32)
				+ (P1W'(kp_a2[2]) << 32) + P1W'(kp_a2[3]);
			sum_a3 <= sum_a2;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pp_a4[i][k] <= p1c[i] * sc[k];
				end
				row_a5[i] <= ROWW'(pp_a4[i][0]) + (ROWW'(pp_a4[i][1]) << 32)
					+ (ROWW'(pp_a4[i][2]) << 64);
			end
			prod_a6 <= PRODW'(row_a5[0]) + (PRODW'(row_a5[1]) << 32)
				+ (PRODW'(row_a5[2]) << 64);
			// Adding |D| ahead of the halved divisor rounds half away from zero.
			num_a7 <= NUMW'(prod_a6 >> 63) + NUMW'(dabs_a[5]);
			d2_a7  <= {dabs_a[5], 1'b0};
			ovf_a8 <= (CMPW'(num_a7) >= (CMPW'(d2_a7) << QW));
			rem_a8 <= num_a7;
			d2_a8  <= d2_a7;
			dabs_a[0] <= sq_dabs_s[SL];
			for (int i = 1; i < 6; i++) begin
				dabs_a[i] <= dabs_a[i-1];
			end
			neg_a   <= {neg_a[6:0], sq_neg_s[SL]};
			degen_a <= {degen_a[6:0], sq_degen_s[SL]};
		end
	end

	// ---------------- divider stages ----------------
	logic [NUMW-1:0]       dv_rem_s [DIV_STAGES];
	logic [QW-1:0]         dv_q_s   [DIV_STAGES];
	logic [D2W-1:0]        dv_d2_s  [DIV_STAGES];
	logic [DIV_STAGES-1:0] dv_ovf_s;
	logic [DIV_STAGES-1:0] dv_neg_s;
	logic [DIV_STAGES-1:0] dv_degen_s;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_dv
		logic [NUMW-1:0] r_in;
		logic [QW-1:0]   q_in;
		logic [D2W-1:0]  d_in;
		logic            ovf_in;
		logic            neg_in;
		logic            degen_in;
		logic [CMPW-1:0] sd;
		logic [CMPW-1:0] rd;

		if (i == 0) begin : g_src
			always_comb begin
				r_in     = rem_a8;
				q_in     = '0;
				d_in     = d2_a8;
				ovf_in   = ovf_a8;
				neg_in   = neg_a[7];
				degen_in = degen_a[7];
			end
		end else begin : g_src
			always_comb begin
				r_in     = dv_rem_s[i-1];
				q_in     = dv_q_s[i-1];
				d_in     = dv_d2_s[i-1];
				ovf_in   = dv_ovf_s[i-1];
				neg_in   = dv_neg_s[i-1];
				degen_in = dv_degen_s[i-1];
			end
		end

		always_comb begin
			sd = CMPW'(d_in) << (QW - 1 - i);
			rd = CMPW'(r_in) - sd;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (CMPW'(r_in) >= sd) begin
					dv_rem_s[i] <= rd[NUMW-1:0];
					dv_q_s[i]   <= {q_in[QW-2:0], 1'b1};
				end else begin
					dv_rem_s[i] <= r_in;
					dv_q_s[i]   <= {q_in[QW-2:0], 1'b0};
				end
				dv_d2_s[i]    <= d_in;
				dv_ovf_s[i]   <= ovf_in;
				dv_neg_s[i]   <= neg_in;
				dv_degen_s[i] <= degen_in;
			end
		end
	end

	// ---------------- output register ----------------
	localparam int DL = DIV_STAGES - 1;

	logic [CW-1:0] qual_q;
	logic          degen_q;
	logic [QW-1:0] qf;

	assign qf         = dv_q_s[DL];
	assign quality    = $signed(qual_q);
	assign degenerate = degen_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			degen_q <= dv_degen_s[DL];
			if (dv_degen_s[DL]) begin
				qual_q <= QUAL_POS_SAT;
			end else if (dv_neg_s[DL]) begin
				if (dv_ovf_s[DL] || (qf > QW'(QUAL_NEG_SAT))) qual_q <= QUAL_NEG_SAT;
				else qual_q <= 32'd0 - qf[CW-1:0];
			end else begin
				if (dv_ovf_s[DL] || (qf > QW'(QUAL_POS_SAT))) qual_q <= QUAL_POS_SAT;
				else qual_q <= qf[CW-1:0];
			end
		end
	end

endmodule

FILE: src/trrq_port_checker.sv
module trrq_port_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic signed [trrq_pkg::CW-1:0] quality,
	input logic                           degenerate
);
	import trrq_pkg::*;

	// A result that waits is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quality) && $stable(degenerate))
		else $error("result changed while stalled");

	// A degenerate element always reports the positive limit.
	a_degen_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> quality == $signed(QUAL_POS_SAT))
		else $error("degenerate result without saturated quality");

	// The input side only stalls while a finished result waits.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> (in_ready == (!out_valid || out_ready)))
		else $error("in_ready does not follow the output stall");

endmodule

bind tetra_radius_ratio_quality_top trrq_port_checker u_trrq_port_checker (.*);
